@@ rtl/plfs_pkg.sv @@
// package: shared constants, command codes, types and word formatting for the frame sender
`timescale 1ns / 1ps

package plfs_pkg;

    // default configuration
    localparam int LED_COUNT_DEF   = 64;
    localparam int CHUNK_LEDS_DEF  = 8;
    localparam int PAL_ENTRIES_DEF = 256;

    // framebuffer geometry (fixed by the led index field)
    localparam int FB_DEPTH = 64;
    localparam int FB_AW    = 6;

    // field widths
    localparam int CMD_W   = 2;
    localparam int PIX_W   = 8;
    localparam int SLOT_W  = 8;
    localparam int COLOR_W = 16;
    localparam int WORD_W  = 32;

    // command codes
    localparam logic [CMD_W-1:0] CMD_SET_PIXEL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PAL_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEND      = 2'd2;

    localparam logic [COLOR_W-1:0] COLOR_WHITE = 16'hFFFF;
    localparam logic [7:0]         LED_HEADER  = 8'hFF;

    // framebuffer write port
    typedef struct packed {
        logic             en;
        logic [FB_AW-1:0] addr;
        logic [PIX_W-1:0] data;
    } t_fb_wr;

    // palette write port (slot already range checked)
    typedef struct packed {
        logic               en;
        logic [SLOT_W-1:0]  addr;
        logic [COLOR_W-1:0] data;
    } t_pal_wr;

    // sequencer status seen by the top level
    typedef struct packed {
        logic busy;
        logic ptr_zero;
    } t_seq_status;

    // rgb565 colour to led frame word: header, blue, green, red, fields unscaled
    function automatic logic [WORD_W-1:0] led_word(input logic [COLOR_W-1:0] c);
        return {LED_HEADER, 3'b000, c[4:0], 2'b00, c[10:5], 3'b000, c[15:11]};
    endfunction

endpackage

@@ rtl/plfs_in_if.sv @@
// interface: command channel carrying one command beat
`timescale 1ns / 1ps

interface plfs_in_if import plfs_pkg::*;;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [FB_AW-1:0]   led_index;
    logic [PIX_W-1:0]   pixel_value;
    logic [SLOT_W-1:0]  palette_slot;
    logic [COLOR_W-1:0] palette_color;

    modport source (
        output valid, command, led_index, pixel_value, palette_slot, palette_color,
        input  ready
    );
    modport sink (
        input  valid, command, led_index, pixel_value, palette_slot, palette_color,
        output ready
    );
endinterface

@@ rtl/plfs_out_if.sv @@
// interface: frame word channel carrying one word beat
`timescale 1ns / 1ps

interface plfs_out_if import plfs_pkg::*;;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] frame_word;
    logic              is_end_word;
    logic              end_of_frame;
    logic              last;

    modport source (
        output valid, frame_word, is_end_word, end_of_frame, last,
        input  ready
    );
    modport sink (
        input  valid, frame_word, is_end_word, end_of_frame, last,
        output ready
    );
endinterface

@@ rtl/plfs_fb_mem.sv @@
// framebuffer memory: 64 colour indices, per-entry valid bits so reset reads zero
`timescale 1ns / 1ps

module plfs_fb_mem import plfs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_fb_wr           i_wr,
    input  logic [FB_AW-1:0] i_raddr,
    output logic [PIX_W-1:0] o_rdata
);

    logic [PIX_W-1:0]    r_mem [FB_DEPTH];
    logic [FB_DEPTH-1:0] r_written;
    logic [PIX_W-1:0]    r_rdata;
    logic                r_rhit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_wr.en) begin
            r_written[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
        r_rhit  <= r_written[i_raddr];
    end

    // never written entries read as zero
    assign o_rdata = r_rhit ? r_rdata : '0;

endmodule

@@ rtl/plfs_pal_mem.sv @@
// palette memory: rgb565 colours, contents undefined until written
`timescale 1ns / 1ps

module plfs_pal_mem import plfs_pkg::*; #(
    parameter int PALETTE_ENTRIES = PAL_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  t_pal_wr            i_wr,
    input  logic [SLOT_W-1:0]  i_raddr,
    output logic [COLOR_W-1:0] o_rdata
);

    localparam int PAW = $clog2(PALETTE_ENTRIES);

    logic [COLOR_W-1:0] r_mem [PALETTE_ENTRIES];
    logic [COLOR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr[PAW-1:0]] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr[PAW-1:0]];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/plfs_seq.sv @@
// send sequencer: led pointer, chunk and end word counters, word formatter and output register
`timescale 1ns / 1ps

module plfs_seq import plfs_pkg::*; #(
    parameter int LED_COUNT       = LED_COUNT_DEF,
    parameter int CHUNK_LEDS      = CHUNK_LEDS_DEF,
    parameter int PALETTE_ENTRIES = PAL_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_palette_valid,
    output logic [FB_AW-1:0]   o_fb_raddr,
    input  logic [PIX_W-1:0]   i_fb_rdata,
    output logic [SLOT_W-1:0]  o_pal_raddr,
    input  logic [COLOR_W-1:0] i_pal_rdata,
    output t_seq_status        o_status,
    plfs_out_if.source         o_word
);

    localparam int END_WORDS = LED_COUNT / 32 + 1;
    localparam int PW        = $clog2(LED_COUNT + 1);
    localparam int CW        = $clog2(CHUNK_LEDS + 1);
    localparam int EW        = $clog2(END_WORDS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FB   = 3'd1;
    localparam logic [2:0] S_PAL  = 3'd2;
    localparam logic [2:0] S_LED  = 3'd3;
    localparam logic [2:0] S_END  = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [PW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_left, n_left;
    logic [EW-1:0] r_ecnt, n_ecnt;
    logic        r_oor;

    logic              r_ovalid;
    logic [WORD_W-1:0] r_oword;
    logic              r_oend;
    logic              r_oeof;
    logic              r_olast;

    logic              out_free;
    logic              load;
    logic [WORD_W-1:0] ld_word;
    logic              ld_end;
    logic              ld_eof;
    logic              ld_last;
    logic [COLOR_W-1:0] colour;
    logic              at_wrap;

    assign out_free    = !r_ovalid || o_word.ready;
    assign o_fb_raddr  = FB_AW'(r_ptr);
    assign o_pal_raddr = i_fb_rdata;
    assign at_wrap     = (r_ptr == PW'(LED_COUNT - 1));

    always_comb begin
        if (!i_palette_valid) begin
            colour = COLOR_WHITE;
        end else if (r_oor) begin
            colour = '0;
        end else begin
            colour = i_pal_rdata;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_left  = r_left;
        n_ecnt  = r_ecnt;
        load    = 1'b0;
        ld_word = '0;
        ld_end  = 1'b0;
        ld_eof  = 1'b0;
        ld_last = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_left  = CW'(CHUNK_LEDS);
                    n_state = S_FB;
                end
            end
            S_FB: begin
                n_state = S_PAL;
            end
            S_PAL: begin
                n_state = S_LED;
            end
            S_LED: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_word = led_word(colour);
                    ld_last = (r_left == CW'(1)) && !at_wrap;
                    n_left  = r_left - CW'(1);
                    if (at_wrap) begin
                        n_ptr   = '0;
                        n_ecnt  = '0;
                        n_state = S_END;
                    end else begin
                        n_ptr   = r_ptr + PW'(1);
                        n_state = (r_left == CW'(1)) ? S_IDLE : S_FB;
                    end
                end
            end
            S_END: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_end  = 1'b1;
                    ld_eof  = (r_ecnt == EW'(END_WORDS - 1));
                    ld_last = ld_eof;
                    n_ecnt  = r_ecnt + EW'(1);
                    if (ld_eof) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ptr    <= '0;
            r_left   <= '0;
            r_ecnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_left  <= n_left;
            r_ecnt  <= n_ecnt;
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (o_word.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // index beyond the palette reads as colour zero
        r_oor <= ({1'b0, i_fb_rdata} >= 9'(PALETTE_ENTRIES));
        if (load) begin
            r_oword <= ld_word;
            r_oend  <= ld_end;
            r_oeof  <= ld_eof;
            r_olast <= ld_last;
        end
    end

    assign o_word.valid        = r_ovalid;
    assign o_word.frame_word   = r_oword;
    assign o_word.is_end_word  = r_oend;
    assign o_word.end_of_frame = r_oeof;
    assign o_word.last         = r_olast;

    assign o_status.busy     = (r_state != S_IDLE);
    assign o_status.ptr_zero = (r_ptr == '0);

endmodule

@@ rtl/palette_led_strip_frame_sender_core.sv @@
// top level: palette led strip frame sender with command decode and palette valid register
// set pixel and palette write land at the accepting edge; a send starts in the cycle after accept
// led words: framebuffer read, palette read, then format, each in its own state; end words need no read
// a full chunk is CHUNK_LEDS leds (eight by default), plus LED_COUNT/32+1 end words on wrap
// leds are read one at a time over the single read path through framebuffer then palette memory
// reset: sequencer, pointer and output valid clear; framebuffer reads zero at once; palette undefined
`timescale 1ns / 1ps

module palette_led_strip_frame_sender_core import plfs_pkg::*; #(
    parameter int LED_COUNT       = LED_COUNT_DEF,
    parameter int CHUNK_LEDS      = CHUNK_LEDS_DEF,
    parameter int PALETTE_ENTRIES = PAL_ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    plfs_in_if.sink    i_cmd,
    plfs_out_if.source o_word,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata
);

    // palette valid register; the user must write it only while idle, the block does not enforce this
    logic r_palette_valid;

    logic        cmd_acc;
    t_fb_wr      fb_wr;
    t_pal_wr     pal_wr;
    t_seq_status status;

    logic [FB_AW-1:0]   fb_raddr;
    logic [PIX_W-1:0]   fb_rdata;
    logic [SLOT_W-1:0]  pal_raddr;
    logic [COLOR_W-1:0] pal_rdata;
    logic               send_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_valid <= 1'b0;
        end else if (i_cfg_we) begin
            r_palette_valid <= i_cfg_wdata;
        end
    end

    // command beats are taken whenever the sequencer is not sending
    assign i_cmd.ready = !status.busy;
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;

    // set pixel goes straight to the framebuffer
    assign fb_wr.en   = cmd_acc && (i_cmd.command == CMD_SET_PIXEL);
    assign fb_wr.addr = i_cmd.led_index;
    assign fb_wr.data = i_cmd.pixel_value;

    // palette write, slots beyond the table are dropped
    assign pal_wr.en   = cmd_acc && (i_cmd.command == CMD_PAL_WRITE)
                         && ({1'b0, i_cmd.palette_slot} < 9'(PALETTE_ENTRIES));
    assign pal_wr.addr = i_cmd.palette_slot;
    assign pal_wr.data = i_cmd.palette_color;

    // the unused command code falls through with no effect
    assign send_start = cmd_acc && (i_cmd.command == CMD_SEND);

    plfs_fb_mem u_fb_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fb_wr),
        .i_raddr (fb_raddr),
        .o_rdata (fb_rdata)
    );

    plfs_pal_mem #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_pal_mem (
        .i_clk   (i_clk),
        .i_wr    (pal_wr),
        .i_raddr (pal_raddr),
        .o_rdata (pal_rdata)
    );

    // sequencer walks the chunk, then the end words when the pointer wraps
    plfs_seq #(
        .LED_COUNT       (LED_COUNT),
        .CHUNK_LEDS      (CHUNK_LEDS),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (send_start),
        .i_palette_valid (r_palette_valid),
        .o_fb_raddr      (fb_raddr),
        .i_fb_rdata      (fb_rdata),
        .o_pal_raddr     (pal_raddr),
        .i_pal_rdata     (pal_rdata),
        .o_status        (status),
        .o_word          (o_word)
    );

    // a send beat always puts the sequencer to work
    a_send_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        send_start |=> status.busy)
        else $error("send accepted but sequencer stayed idle");

    // writes and unused commands never start a send
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_acc && !send_start) |=> !status.busy)
        else $error("non-send command started the sequencer");

    // the end of a frame leaves the led pointer wrapped to zero
    a_eof_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_word.valid && o_word.end_of_frame) |-> status.ptr_zero)
        else $error("end of frame with led pointer not wrapped");

endmodule

@@ sim/tb.sv @@
// testbench: frame sender checked beat by beat against a mirror of its framebuffer and palette
`timescale 1ns / 1ps

module tb;
    import plfs_pkg::*;

    // block geometry, kept at the package defaults
    localparam int LEDS      = LED_COUNT_DEF;
    localparam int CHUNK     = CHUNK_LEDS_DEF;
    localparam int PAL_SLOTS = PAL_ENTRIES_DEF;
    localparam int END_WORDS = LEDS / 32 + 1;

    // the one command code the block must ignore
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // colour words that can be read straight off the format
    localparam logic [WORD_W-1:0] WORD_WHITE = 32'hFF1F_3F1F;
    localparam logic [WORD_W-1:0] WORD_BLACK = 32'hFF00_0000;

    // quiet time before a register write, covers a command still in flight
    localparam int SETTLE_CYCLES = 30;
    // trailing cycles after the last expected word, catches stray extras
    localparam int TAIL_CYCLES   = 40;
    // hard stop, far beyond the slowest legal run
    localparam int TIMEOUT_NS    = 5_000_000;
    // stop printing after this many mismatches, keep counting
    localparam int PRINT_CAP     = 40;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [FB_AW-1:0]   led_index;
        logic [PIX_W-1:0]   pixel_value;
        logic [SLOT_W-1:0]  palette_slot;
        logic [COLOR_W-1:0] palette_color;
    } t_cmd_beat;

    typedef struct packed {
        logic [WORD_W-1:0] frame_word;
        logic              is_end_word;
        logic              end_of_frame;
        logic              last;
    } t_strip_word;

    typedef enum logic {ROW_BEAT, ROW_CFG} t_row_kind;

    // one row of the directed script: a command beat or a register write,
    // with an optional hand-typed value for every led word the beat causes
    typedef struct packed {
        t_row_kind         kind;
        logic              cfg_value;
        t_cmd_beat         beat;
        logic              typed;
        logic [WORD_W-1:0] led_word;
    } t_script_row;

    localparam int N_ROWS = 22;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    plfs_in_if  cmd_ch ();
    plfs_out_if word_ch ();

    palette_led_strip_frame_sender_core #(
        .LED_COUNT       (LEDS),
        .CHUNK_LEDS      (CHUNK),
        .PALETTE_ENTRIES (PAL_SLOTS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_ch),
        .o_word      (word_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // mirror of the block state, updated as each command beat is accepted
    logic [PIX_W-1:0]   fb_mirror  [FB_DEPTH];
    logic [COLOR_W-1:0] pal_mirror [PAL_SLOTS];
    bit                 pal_known  [PAL_SLOTS];
    int                 next_led;
    bit                 pal_on;

    // words still owed by the block, oldest first
    t_strip_word pending_words [$];

    int mismatches = 0;

    // idling percentages, changed per phase
    int send_gap_pct   = 22;
    int recv_stall_pct = 47;

    t_script_row script [N_ROWS];

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP) $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    // rgb565 to led word: header byte, then blue, green and red fields unscaled
    function automatic logic [WORD_W-1:0] strip_colour_word(input logic [COLOR_W-1:0] c);
        logic [WORD_W-1:0] red;
        logic [WORD_W-1:0] green;
        logic [WORD_W-1:0] blue;
        red   = WORD_W'((c & 16'hF800) >> 11);
        green = WORD_W'((c & 16'h07E0) >> 5);
        blue  = WORD_W'(c & 16'h001F);
        return 32'hFF00_0000 | (blue << 16) | (green << 8) | red;
    endfunction

    // apply one accepted beat to the mirror and queue the words it causes;
    // a typed value, where given, replaces the computed led words
    function automatic void predict_beat(input t_cmd_beat b, input logic typed,
                                         input logic [WORD_W-1:0] typed_word);
        int          n_led;
        int          total;
        bit          wraps;
        logic [7:0]  ci;
        logic [15:0] colour;
        t_strip_word w;
        case (b.command)
            CMD_SET_PIXEL: begin
                fb_mirror[b.led_index] = b.pixel_value;
            end
            CMD_PAL_WRITE: begin
                if (int'(b.palette_slot) < PAL_SLOTS) begin
                    pal_mirror[b.palette_slot] = b.palette_color;
                    pal_known[b.palette_slot]  = 1'b1;
                end
            end
            CMD_SEND: begin
                n_led = (LEDS - next_led < CHUNK) ? LEDS - next_led : CHUNK;
                wraps = (next_led + n_led >= LEDS);
                total = n_led + (wraps ? END_WORDS : 0);
                for (int k = 0; k < total; k++) begin
                    if (k < n_led) begin
                        ci = fb_mirror[(next_led + k) % FB_DEPTH];
                        if (!pal_on)
                            colour = 16'hFFFF;
                        else if (int'(ci) >= PAL_SLOTS)
                            colour = '0;
                        else
                            colour = pal_mirror[ci];
                        w.frame_word   = typed ? typed_word : strip_colour_word(colour);
                        w.is_end_word  = 1'b0;
                        w.end_of_frame = 1'b0;
                    end else begin
                        w.frame_word   = '0;
                        w.is_end_word  = 1'b1;
                        w.end_of_frame = (k == total - 1);
                    end
                    w.last = (k == total - 1);
                    pending_words.push_back(w);
                end
                next_led = wraps ? 0 : next_led + n_led;
            end
            default: ;
        endcase
    endfunction

    // offer one beat on the command channel, with random gaps before it;
    // valid is left high after the accepting edge and dealt with at the next falling edge
    task automatic push_cmd(input t_cmd_beat b, input logic typed,
                            input logic [WORD_W-1:0] typed_word);
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.command       <= b.command;
        cmd_ch.led_index     <= b.led_index;
        cmd_ch.pixel_value   <= b.pixel_value;
        cmd_ch.palette_slot  <= b.palette_slot;
        cmd_ch.palette_color <= b.palette_color;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        predict_beat(b, typed, typed_word);
    endtask

    // drop valid and wait for every owed word to drain
    task automatic drain_words();
        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;
        while (pending_words.size() != 0) @(negedge i_clk);
    endtask

    // register write only while idle; set pixel and palette write leave no word
    // to wait for, so allow a settling gap on top of the drain
    task automatic set_palette_valid(input logic v);
        drain_words();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        pal_on = v;
    endtask

    // with the palette in use, every colour index the next chunk reads must have been
    // written; write any missing slot with a random colour first
    task automatic cover_unwritten_slots();
        t_cmd_beat  b;
        int         stop;
        logic [7:0] ci;
        stop = (next_led + CHUNK < LEDS) ? next_led + CHUNK : LEDS;
        for (int p = next_led; p < stop; p++) begin
            ci = fb_mirror[p % FB_DEPTH];
            if (!pal_known[ci]) begin
                b.command       = CMD_PAL_WRITE;
                b.led_index     = FB_AW'($urandom);
                b.pixel_value   = PIX_W'($urandom);
                b.palette_slot  = ci;
                b.palette_color = COLOR_W'($urandom);
                push_cmd(b, 1'b0, '0);
            end
        end
    endtask

    // random command mix; ignored beats are sent but not counted
    task automatic run_random_phase(input int n_items);
        t_cmd_beat b;
        int        done;
        int        pick;
        done = 0;
        while (done < n_items) begin
            pick            = $urandom_range(99);
            b.led_index     = FB_AW'($urandom);
            b.pixel_value   = PIX_W'($urandom);
            b.palette_slot  = SLOT_W'($urandom);
            b.palette_color = COLOR_W'($urandom);
            if (pick < 35) begin
                b.command = CMD_SET_PIXEL;
            end else if (pick < 60) begin
                b.command = CMD_PAL_WRITE;
            end else if (pick < 95) begin
                b.command = CMD_SEND;
                if (pal_on) cover_unwritten_slots();
            end else begin
                b.command = CMD_UNUSED;
            end
            push_cmd(b, 1'b0, '0);
            if (b.command != CMD_UNUSED) done++;
        end
    endtask

    // receiver: ready changes at the falling edge with random stalls
    always @(negedge i_clk) begin
        word_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // every accepted word beat is matched against the oldest owed word
    always @(posedge i_clk) begin
        t_strip_word got;
        t_strip_word want;
        if (i_rst_n && word_ch.valid && word_ch.ready) begin
            got.frame_word   = word_ch.frame_word;
            got.is_end_word  = word_ch.is_end_word;
            got.end_of_frame = word_ch.end_of_frame;
            got.last         = word_ch.last;
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", got.frame_word));
            end else begin
                want = pending_words.pop_front();
                if (got.frame_word !== want.frame_word)
                    report_mismatch($sformatf("frame_word %h, want %h",
                                              got.frame_word, want.frame_word));
                if (got.is_end_word !== want.is_end_word)
                    report_mismatch($sformatf("is_end_word %b, want %b",
                                              got.is_end_word, want.is_end_word));
                if (got.end_of_frame !== want.end_of_frame)
                    report_mismatch($sformatf("end_of_frame %b, want %b",
                                              got.end_of_frame, want.end_of_frame));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last %b, want %b", got.last, want.last));
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        t_script_row row;

        cmd_ch.valid         = 1'b0;
        cmd_ch.command       = CMD_SET_PIXEL;
        cmd_ch.led_index     = '0;
        cmd_ch.pixel_value   = '0;
        cmd_ch.palette_slot  = '0;
        cmd_ch.palette_color = '0;
        word_ch.ready        = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_wdata          = 1'b0;
        i_rst_n              = 1'b0;

        for (int i = 0; i < FB_DEPTH; i++) fb_mirror[i] = '0;
        for (int i = 0; i < PAL_SLOTS; i++) begin
            pal_mirror[i] = '0;
            pal_known[i]  = 1'b0;
        end
        next_led = 0;
        pal_on   = 1'b0;

        // directed script; framebuffer starts all zero and the palette is off
        //                 kind      cfg   cmd            idx    pix    slot   colour    typed word
        script[0]  = '{ROW_BEAT, 1'b0, '{CMD_SEND,      6'd0,  8'h00, 8'h00, 16'h0000}, 1'b1, WORD_WHITE};
        script[1]  = '{ROW_BEAT, 1'b0, '{CMD_UNUSED,    6'd63, 8'hFF, 8'hFF, 16'hFFFF}, 1'b0, '0};
        script[2]  = '{ROW_BEAT, 1'b0, '{CMD_SET_PIXEL, 6'd63, 8'hFF, 8'h00, 16'h0000}, 1'b0, '0};
        script[3]  = '{ROW_BEAT, 1'b0, '{CMD_SET_PIXEL, 6'd0,  8'h00, 8'hFF, 16'hFFFF}, 1'b0, '0};
        script[4]  = '{ROW_BEAT, 1'b0, '{CMD_PAL_WRITE, 6'd0,  8'h00, 8'h00, 16'h0000}, 1'b0, '0};
        script[5]  = '{ROW_BEAT, 1'b0, '{CMD_PAL_WRITE, 6'd63, 8'hFF, 8'hFF, 16'hFFFF}, 1'b0, '0};
        script[6]  = '{ROW_BEAT, 1'b0, '{CMD_PAL_WRITE, 6'd0,  8'h00, 8'h80, 16'hF800}, 1'b0, '0};
        script[7]  = '{ROW_BEAT, 1'b0, '{CMD_PAL_WRITE, 6'd0,  8'h00, 8'h01, 16'h07E0}, 1'b0, '0};
        script[8]  = '{ROW_BEAT, 1'b0, '{CMD_PAL_WRITE, 6'd0,  8'h00, 8'h02, 16'h001F}, 1'b0, '0};
        script[9]  = '{ROW_CFG,  1'b1, '{CMD_SET_PIXEL, 6'd0,  8'h00, 8'h00, 16'h0000}, 1'b0, '0};
        script[10] = '{ROW_BEAT, 1'b0, '{CMD_SEND,      6'd0,  8'h00, 8'h00, 16'h0000}, 1'b1, WORD_BLACK};
        script[11] = '{ROW_BEAT, 1'b0, '{CMD_SET_PIXEL, 6'd16, 8'h80, 8'h00, 16'h0000}, 1'b0, '0};
        script[12] = '{ROW_BEAT, 1'b0, '{CMD_SET_PIXEL, 6'd17, 8'h01, 8'h00, 16'h0000}, 1'b0, '0};
        script[13] = '{ROW_BEAT, 1'b0, '{CMD_SET_PIXEL, 6'd18, 8'h02, 8'h00, 16'h0000}, 1'b0, '0};
        script[14] = '{ROW_BEAT, 1'b0, '{CMD_SEND,      6'd0,  8'h00, 8'h00, 16'h0000}, 1'b0, '0};
        script[15] = '{ROW_BEAT, 1'b0, '{CMD_SEND,      6'd0,  8'h00, 8'h00, 16'h0000}, 1'b1, WORD_BLACK};
        script[16] = '{ROW_BEAT, 1'b0, '{CMD_SEND,      6'd0,  8'h00, 8'h00, 16'h0000}, 1'b1, WORD_BLACK};
        script[17] = '{ROW_BEAT, 1'b0, '{CMD_SEND,      6'd0,  8'h00, 8'h00, 16'h0000}, 1'b1, WORD_BLACK};
        script[18] = '{ROW_BEAT, 1'b0, '{CMD_SEND,      6'd0,  8'h00, 8'h00, 16'h0000}, 1'b1, WORD_BLACK};
        script[19] = '{ROW_BEAT, 1'b0, '{CMD_SEND,      6'd0,  8'h00, 8'h00, 16'h0000}, 1'b0, '0};
        script[20] = '{ROW_CFG,  1'b0, '{CMD_SET_PIXEL, 6'd0,  8'h00, 8'h00, 16'h0000}, 1'b0, '0};
        script[21] = '{ROW_BEAT, 1'b0, '{CMD_SEND,      6'd0,  8'h00, 8'h00, 16'h0000}, 1'b1, WORD_WHITE};

        // synchronous reset, released on a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, sender gaps light and receiver stalls heavy
        for (int i = 0; i < N_ROWS; i++) begin
            row = script[i];
            if (row.kind == ROW_CFG)
                set_palette_valid(row.cfg_value);
            else
                push_cmd(row.beat, row.typed, row.led_word);
        end

        // random phases: palette on with light sender gaps, then off with the
        // idling swapped, then on again with both sides flat out
        set_palette_valid(1'b1);
        run_random_phase(40);

        send_gap_pct   = 47;
        recv_stall_pct = 22;
        set_palette_valid(1'b0);
        run_random_phase(40);

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        set_palette_valid(1'b1);
        run_random_phase(40);

        drain_words();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
